@@ rtl/glyph_rasterizer_5x7_unit_macros.svh @@
// Assertion helpers for the character generator.
// Each macro expects clk and rst_n in scope and disables itself during reset.
`ifndef GLYPH_RASTERIZER_5X7_UNIT_MACROS_SVH
`define GLYPH_RASTERIZER_5X7_UNIT_MACROS_SVH

// Same-cycle implication.
`define GR5X7_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GR5X7_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gr5x7_pkg.sv @@
`default_nettype none

package gr5x7_pkg;

    // Field widths.
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int CODE_W     = 8;
    localparam int OFFSET_W   = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 8'd1;

    // Default glyph geometry.
    localparam int GLYPH_COLS_DEF   = 5;
    localparam int GLYPH_ROWS_DEF   = 7;
    localparam int CHAR_ADVANCE_DEF = 6;

    // Column and row counters cover up to eight columns and eight rows.
    localparam int IDX_W = 3;

    // Font storage: one byte per column, bit 0 is the top row.
    localparam int FONT_WIDTH  = 5;
    localparam int FONT_BITS   = 8;
    localparam int FONT_COUNT  = 95;
    localparam int FONT_ADDR_W = 7;
    localparam logic [CODE_W-1:0] FONT_FIRST = 8'd32;
    localparam logic [CODE_W-1:0] FONT_LAST  = 8'd126;

    typedef logic [FONT_WIDTH-1:0][FONT_BITS-1:0] glyph_t;

    typedef struct packed {
        logic               start_req;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CODE_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } pixel_t;

    // Character handed from the input buffer to the raster sequencer.
    typedef struct packed {
        logic  valid;
        item_t item;
    } char_req_t;

    localparam logic [FONT_BITS-1:0] FONT_BYTES [FONT_COUNT][FONT_WIDTH] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h10,8'h08,8'h08,8'h10,8'h08}
    };

endpackage

`default_nettype wire

@@ rtl/glyph_rasterizer_5x7_unit.sv @@
// 5x7 character generator.
// Input channel (item_valid/item_ready/item_data): one character per transfer,
// with its code, colors and an optional start position for the cursor.
// Output channel (pixel_valid/pixel_ready/pixel_data): GLYPH_COLS * GLYPH_ROWS
// pixels per character (35 by default), column by column, top row first, the
// final one flagged by last.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// writes x_offset, index 1 writes y_offset, low 10 bits kept, others ignored.
// It is always ready; write it only while no character is in flight.
// Registers between an input transfer and its first pixel: input buffer and
// font ROM, sequencer, output. Throughput: one pixel per cycle while the
// receiver does not stall; the raster sequencer's pixel walk sets this rate.
// The font lookup is a synchronous ROM read issued at the input transfer,
// and a one-entry buffer takes the next character while one is being drawn.
// Reset clears the cursor to 0,0, both offsets to 0 and all valid flags.
// When the receiver stalls, the current pixel holds in the output register,
// the walk pauses and input stops once the buffer holds a waiting character.
`default_nettype none

module glyph_rasterizer_5x7_unit #(
    parameter int GLYPH_COLS   = gr5x7_pkg::GLYPH_COLS_DEF,
    parameter int GLYPH_ROWS   = gr5x7_pkg::GLYPH_ROWS_DEF,
    parameter int CHAR_ADVANCE = gr5x7_pkg::CHAR_ADVANCE_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              item_valid,
    output logic                             item_ready,
    input  gr5x7_pkg::item_t                 item_data,
    output logic                             pixel_valid,
    input  wire                              pixel_ready,
    output gr5x7_pkg::pixel_t                pixel_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [gr5x7_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [gr5x7_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gr5x7_pkg::*;

`include "glyph_rasterizer_5x7_unit_macros.svh"

    logic [OFFSET_W-1:0] x_offset_reg, y_offset_reg;
    logic                buf_valid_reg, buf_valid_next;
    item_t               buf_item_reg;
    logic                item_xfer;
    logic                take;
    logic                busy;
    glyph_t              glyph;
    char_req_t           req;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= '0;
            y_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_X_OFFSET)
            begin
                x_offset_reg <= cfg_data[OFFSET_W-1:0];
            end
            else if (cfg_index == REG_Y_OFFSET)
            begin
                y_offset_reg <= cfg_data[OFFSET_W-1:0];
            end
        end
    end

    // One-entry input buffer; it frees up in the cycle the sequencer loads it.
    always_comb
    begin
        item_ready     = !buf_valid_reg || take;
        item_xfer      = item_valid && item_ready;
        buf_valid_next = item_xfer ? 1'b1 : (buf_valid_reg && !take);
        req.valid      = buf_valid_reg;
        req.item       = buf_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            buf_item_reg <= item_data;
        end
    end

    // Font lookup runs alongside the buffer write, so the glyph matches it.
    gr5x7_font_rom u_font_rom (
        .clk   (clk),
        .rd_en (item_xfer),
        .code  (item_data.char_code),
        .glyph (glyph)
    );

    gr5x7_raster #(
        .GLYPH_COLS   (GLYPH_COLS),
        .GLYPH_ROWS   (GLYPH_ROWS),
        .CHAR_ADVANCE (CHAR_ADVANCE)
    ) u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .glyph       (glyph),
        .x_offset    (x_offset_reg),
        .y_offset    (y_offset_reg),
        .take        (take),
        .busy        (busy),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_data  (pixel_data)
    );

    // A waiting character only blocks input while another one is being drawn.
    `GR5X7_ASSERT_IMPLY(a_stall_only_when_busy, !item_ready, busy, "input stalled while idle")
    // Pixels of one character follow each other without a gap.
    `GR5X7_ASSERT_NEXT(a_no_gap_in_char, pixel_valid && pixel_ready && !pixel_data.last, pixel_valid, "gap inside a character")
    // A loaded character always comes from a filled buffer.
    `GR5X7_ASSERT_IMPLY(a_take_from_buffer, take, buf_valid_reg, "load from empty buffer")

endmodule

`default_nettype wire

@@ rtl/gr5x7_font_rom.sv @@
`default_nettype none

module gr5x7_font_rom (
    input  wire                        clk,
    input  wire                        rd_en,
    input  wire  [gr5x7_pkg::CODE_W-1:0] code,
    output gr5x7_pkg::glyph_t           glyph
);
    import gr5x7_pkg::*;

    logic [FONT_ADDR_W-1:0] addr;
    glyph_t                 glyph_reg;

    // Unprintable codes map to entry zero, which is the blank space glyph.
    always_comb
    begin
        if (code >= FONT_FIRST && code <= FONT_LAST)
        begin
            addr = FONT_ADDR_W'(code - FONT_FIRST);
        end
        else
        begin
            addr = '0;
        end
    end

    // Synchronous read with registered data; holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int c = 0; c < FONT_WIDTH; c++)
            begin
                glyph_reg[c] <= FONT_BYTES[addr][c];
            end
        end
    end

    assign glyph = glyph_reg;

endmodule

`default_nettype wire

@@ rtl/gr5x7_raster.sv @@
`default_nettype none

module gr5x7_raster #(
    parameter int GLYPH_COLS   = gr5x7_pkg::GLYPH_COLS_DEF,
    parameter int GLYPH_ROWS   = gr5x7_pkg::GLYPH_ROWS_DEF,
    parameter int CHAR_ADVANCE = gr5x7_pkg::CHAR_ADVANCE_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  gr5x7_pkg::char_req_t           req,
    input  gr5x7_pkg::glyph_t              glyph,
    input  wire  [gr5x7_pkg::OFFSET_W-1:0] x_offset,
    input  wire  [gr5x7_pkg::OFFSET_W-1:0] y_offset,
    output logic                           take,
    output logic                           busy,
    output logic                           pixel_valid,
    input  wire                            pixel_ready,
    output gr5x7_pkg::pixel_t              pixel_data
);
    import gr5x7_pkg::*;

    localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(GLYPH_COLS - 1);
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(GLYPH_ROWS - 1);

    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] org_x_reg, org_y_reg;
    logic [COLOR_W-1:0] fg_reg, bg_reg;
    glyph_t             glyph_reg;
    pixel_t             out_reg;

    logic               adv;
    logic               at_last;
    logic [COORD_W-1:0] base_x, base_y;
    logic               bit_on;
    pixel_t             pix;

    // Step control: one pixel per cycle while the output stage can take it.
    always_comb
    begin
        adv     = busy_reg && (!out_valid_reg || pixel_ready);
        at_last = (col_reg == COL_LAST) && (row_reg == ROW_LAST);
        take    = req.valid && (!busy_reg || (adv && at_last));
        base_x  = req.item.start_req ? req.item.pos_x : cursor_x_reg;
        base_y  = req.item.start_req ? req.item.pos_y : cursor_y_reg;
    end

    // Next state of the column/row walk and the cursor.
    always_comb
    begin
        busy_next     = busy_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (take)
        begin
            busy_next     = 1'b1;
            col_next      = '0;
            row_next      = '0;
            cursor_x_next = base_x + COORD_W'(CHAR_ADVANCE);
            cursor_y_next = base_y;
        end
        else if (adv)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else if (row_reg == ROW_LAST)
            begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
        out_valid_next = adv ? 1'b1 : (out_valid_reg && !pixel_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pixel of the current step; columns past the font width are blank.
    always_comb
    begin
        if (32'(col_reg) < FONT_WIDTH)
        begin
            bit_on = glyph_reg[col_reg][row_reg];
        end
        else
        begin
            bit_on = 1'b0;
        end
        pix.pixel_x     = org_x_reg + COORD_W'(col_reg);
        pix.pixel_y     = org_y_reg + COORD_W'(row_reg);
        pix.pixel_color = bit_on ? fg_reg : bg_reg;
        pix.last        = at_last;
    end

    // Character context is latched at load; the output stage on each step.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            org_x_reg <= base_x + COORD_W'(x_offset);
            org_y_reg <= base_y + COORD_W'(y_offset);
            fg_reg    <= req.item.fg_color;
            bg_reg    <= req.item.bg_color;
            glyph_reg <= glyph;
        end
        if (adv)
        begin
            out_reg <= pix;
        end
    end

    assign busy        = busy_reg;
    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_reg;

endmodule

`default_nettype wire

@@ tb/glyph_rasterizer_5x7_unit_test.sv @@
`timescale 1ns / 1ps

module glyph_rasterizer_5x7_unit_test;

    import gr5x7_pkg::*;

    // Glyph geometry of the default instance.
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int CHAR_ADVANCE = 6;
    localparam int GLYPH_PIXELS = GLYPH_COLS * GLYPH_ROWS;

    // Printable range of the font.
    localparam logic [7:0] PRINTABLE_FIRST = 8'd32;
    localparam logic [7:0] PRINTABLE_LAST  = 8'd126;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

    localparam int RX_STALL_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // Font bitmaps, five column bytes per character, column 0 in the top byte.
    // Bit 0 of each byte is the top row.
    localparam logic [39:0] CHAR_BITMAPS [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item_data = '0;
    logic                  pixel_valid;
    logic                  pixel_ready = 1'b0;
    pixel_t                pixel_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Characters waiting to be offered and pixels waiting to be seen.
    item_t  pending_chars[$];
    pixel_t expected_pixels[$];

    // Predicted block state.
    logic [COORD_W-1:0]  pen_x = '0;
    logic [COORD_W-1:0]  pen_y = '0;
    logic [OFFSET_W-1:0] panel_x_offset = '0;
    logic [OFFSET_W-1:0] panel_y_offset = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        rx_stall_armed = 1'b0;
    int          rx_stall_cycles = 0;
    int          pixel_errors = 0;
    int          quiet_cycles = 0;

    glyph_rasterizer_5x7_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_data   (item_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_data  (pixel_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Column byte of a character; unprintable codes are blank.
    function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
        logic [39:0] bitmap;
        if (code < PRINTABLE_FIRST || code > PRINTABLE_LAST)
        begin
            return 8'h00;
        end
        bitmap = CHAR_BITMAPS[code - PRINTABLE_FIRST];
        return bitmap[39 - 8 * col -: 8];
    endfunction

    // Predict the pixels of one character and advance the pen.
    function automatic void draw_character(input item_t ch);
        logic [7:0] column_bits;
        pixel_t     px;
        int         count;
        int         col;
        int         row;
        if (ch.start_req)
        begin
            pen_x = ch.pos_x;
            pen_y = ch.pos_y;
        end
        count = 0;
        for (col = 0; col < GLYPH_COLS; col++)
        begin
            column_bits = font_column(ch.char_code, col);
            for (row = 0; row < GLYPH_ROWS; row++)
            begin
                count++;
                px.pixel_x     = pen_x + COORD_W'(col) + COORD_W'(panel_x_offset);
                px.pixel_y     = pen_y + COORD_W'(row) + COORD_W'(panel_y_offset);
                px.pixel_color = column_bits[row] ? ch.fg_color : ch.bg_color;
                px.last        = (count == GLYPH_PIXELS);
                expected_pixels.push_back(px);
            end
        end
        pen_x = pen_x + COORD_W'(CHAR_ADVANCE);
    endfunction

    function automatic item_t make_char(input logic start, input logic [15:0] x,
                                        input logic [15:0] y, input logic [7:0] code,
                                        input logic [15:0] fg, input logic [15:0] bg);
        item_t ch;
        ch.start_req = start;
        ch.pos_x     = x;
        ch.pos_y     = y;
        ch.char_code = code;
        ch.fg_color  = fg;
        ch.bg_color  = bg;
        return ch;
    endfunction

    // Driver: offers queued characters and predicts each one at its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_data  <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                draw_character(item_data);
            end
            if (!item_valid || item_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_data  <= pending_chars.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each pixel transfer and throttles the output side.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            pixel_ready     <= 1'b0;
            rx_stall_cycles <= 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with no character pending: x %0d, y %0d",
                           pixel_data.pixel_x, pixel_data.pixel_y);
                    pixel_errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_data.pixel_x !== want.pixel_x)
                    begin
                        $error("pixel_x: expected %0d, actual %0d",
                               want.pixel_x, pixel_data.pixel_x);
                        pixel_errors++;
                    end
                    if (pixel_data.pixel_y !== want.pixel_y)
                    begin
                        $error("pixel_y: expected %0d, actual %0d",
                               want.pixel_y, pixel_data.pixel_y);
                        pixel_errors++;
                    end
                    if (pixel_data.pixel_color !== want.pixel_color)
                    begin
                        $error("pixel_color: expected %h, actual %h",
                               want.pixel_color, pixel_data.pixel_color);
                        pixel_errors++;
                    end
                    if (pixel_data.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d",
                               want.last, pixel_data.last);
                        pixel_errors++;
                    end
                end
            end
            // A long hold-off once armed, random back-pressure otherwise.
            if (rx_stall_armed && rx_stall_cycles < RX_STALL_LEN)
            begin
                pixel_ready     <= 1'b0;
                rx_stall_cycles <= rx_stall_cycles + 1;
            end
            else
            begin
                pixel_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: counts cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (pixel_valid && pixel_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Register write over the configuration channel; only used while idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_X_OFFSET: panel_x_offset = value[OFFSET_W-1:0];
            REG_Y_OFFSET: panel_y_offset = value[OFFSET_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || item_valid || expected_pixels.size() != 0);
    endtask

    // Runs of text: a positioned character followed by continuations, with
    // some stray restarts, runs without a start and unprintable bytes.
    task automatic queue_random_text(input int total);
        item_t ch;
        int    run_len;
        int    queued;
        int    i;
        queued = 0;
        while (queued < total)
        begin
            run_len = $urandom_range(12, 1);
            for (i = 0; i < run_len; i++)
            begin
                if (i == 0)
                    ch.start_req = ($urandom_range(9) != 0);
                else
                    ch.start_req = ($urandom_range(19) == 0);
                ch.pos_x = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 65500))
                                                     : 16'($urandom);
                ch.pos_y = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 65500))
                                                     : 16'($urandom);
                ch.char_code = ($urandom_range(9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(126, 32));
                ch.fg_color = 16'($urandom);
                ch.bg_color = 16'($urandom);
                pending_chars.push_back(ch);
            end
            queued += run_len;
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Offsets at reset: continuing before any start, font range ends,
        // unprintable codes, coordinate and cursor wrap.
        pending_chars.push_back(make_char(1'b0, 16'h1234, 16'h4321, 8'h41, 16'hF800, 16'h001F));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'h42, 16'h07E0, 16'h0000));
        pending_chars.push_back(make_char(1'b1, 16'h0000, 16'h0000, 8'd32, 16'hFFFF, 16'h0000));
        pending_chars.push_back(make_char(1'b0, 16'hFFFF, 16'hFFFF, 8'd126, 16'h0000, 16'hFFFF));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'd31, 16'hFFFF, 16'h1234));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'd127, 16'hFFFF, 16'h4321));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'd0, 16'hFFFF, 16'h5A5A));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'd255, 16'hFFFF, 16'hA5A5));
        pending_chars.push_back(make_char(1'b1, 16'hFFFF, 16'hFFFF, 8'h23, 16'hAAAA, 16'h5555));
        pending_chars.push_back(make_char(1'b1, 16'd65530, 16'd1000, 8'h40, 16'h5555, 16'hAAAA));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'h57, 16'h8001, 16'h7FFE));
        wait_until_drained();

        // Largest offsets, masked writes and writes to unused indexes.
        write_register(REG_X_OFFSET, 16'hFFFF);
        write_register(REG_Y_OFFSET, 16'h03FF);
        write_register(REG_UNUSED, 16'h1234);
        write_register(REG_TOP, 16'hFFFF);
        pending_chars.push_back(make_char(1'b1, 16'hFFFF, 16'hFFFF, 8'h4D, 16'hFFFF, 16'h0000));
        pending_chars.push_back(make_char(1'b1, 16'hFC00, 16'hFC00, 8'h38, 16'h0F0F, 16'hF0F0));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'h67, 16'h3333, 16'hCCCC));
        pending_chars.push_back(make_char(1'b0, 16'h0000, 16'h0000, 8'h80, 16'h3333, 16'hCCCC));
        wait_until_drained();

        // Mostly busy sender against a mostly stalled receiver.
        send_idle_pct = 24;
        recv_idle_pct = 86;
        write_register(REG_X_OFFSET, 16'($urandom));
        write_register(REG_Y_OFFSET, 16'($urandom));
        queue_random_text(90);
        wait_until_drained();

        // Mostly idle sender against a fast receiver.
        send_idle_pct = 86;
        recv_idle_pct = 24;
        write_register(REG_X_OFFSET, 16'h0000);
        write_register(REG_Y_OFFSET, 16'hFFFF);
        queue_random_text(90);
        wait_until_drained();

        // Full rate after a long receiver hold-off that backs up the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(REG_X_OFFSET, 16'($urandom));
        write_register(REG_Y_OFFSET, 16'h0000);
        rx_stall_armed = 1'b1;
        queue_random_text(100);
        wait_until_drained();

        repeat (8) @(posedge clk);
        @(negedge clk);
        if (pixel_errors == 0 && expected_pixels.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            if (expected_pixels.size() != 0)
                $error("%0d expected pixels never arrived", expected_pixels.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
